// File: design/tslf_pkg.sv
// Shared types and constants for the text stream line formatter.
package tslf_pkg;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 2;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOLLAR_EOL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CARET_TAB     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CARET_CTRL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SQUEEZE_BLANK = 3'd4;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_UPPER_I = 8'h49;
    localparam logic [7:0] CH_UPPER_M = 8'h4D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_PRINT_LO = 8'h20;
    localparam logic [7:0] CH_PRINT_HI = 8'h7E;
    localparam logic [7:0] MASK_LOW7 = 8'h7F;
    localparam logic [7:0] MASK_CTRL = 8'h40;

    typedef struct packed {
        logic [1:0] number_mode;
        logic       dollar_eol;
        logic       caret_tab;
        logic       caret_ctrl;
        logic       squeeze_blank;
    } t_cfg;

    // One classified input byte: optional number prefix and one to three body bytes.
    typedef struct packed {
        logic       num_en;
        logic [1:0] body_len;
        logic [7:0] body2;
        logic [7:0] body1;
        logic [7:0] body0;
    } t_cmd;

endpackage

// File: design/tslf_queue.sv
// Small first-in first-out queue between front and back sections.
module tslf_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_din,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_dout,
    output logic         o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_dout  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_din;
        end
    end

endmodule

// File: design/tslf_front.sv
// Front section: accept bytes, track line state and counter, classify into commands.
module tslf_front #(
    parameter int NUMBER_DIGITS = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tslf_pkg::t_cfg               i_cfg,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [7:0]                   i_data_byte,
    input  logic                         i_file_start,
    input  logic                         i_q_full,
    output logic                         o_push,
    output tslf_pkg::t_cmd               o_cmd,
    output logic [4*NUMBER_DIGITS-1:0]   o_digits
);
    import tslf_pkg::*;

    localparam int CNT_W = 4 * NUMBER_DIGITS;

    logic [CNT_W-1:0] r_count, n_count;
    logic             r_at_start, n_at_start;
    logic             r_prev_empty, n_prev_empty;

    logic   accept;
    logic   start_eff;
    logic   prev_empty_eff;
    logic   squeeze;
    logic   numbering;
    logic   is_nl;
    logic   all_nine;
    logic   carry;
    logic [3:0] dig;
    logic [CNT_W-1:0] count_inc;
    t_cmd   cmd;

    assign o_ready   = !i_q_full;
    assign accept    = i_valid && o_ready;
    assign numbering = (i_cfg.number_mode != 2'd0);
    assign is_nl     = (i_data_byte == CH_NL);
    assign start_eff      = r_at_start || i_file_start;
    assign prev_empty_eff = r_at_start ? r_prev_empty : 1'b0;
    assign squeeze   = is_nl && start_eff && i_cfg.squeeze_blank && prev_empty_eff;

    // saturating BCD increment
    always_comb begin
        all_nine  = 1'b1;
        carry     = 1'b1;
        count_inc = r_count;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            dig = r_count[4*i +: 4];
            if (dig != 4'd9) begin
                all_nine = 1'b0;
            end
            if (carry) begin
                if (dig >= 4'd9) begin
                    count_inc[4*i +: 4] = 4'd0;
                end else begin
                    count_inc[4*i +: 4] = dig + 4'd1;
                    carry = 1'b0;
                end
            end
        end
        if (all_nine) begin
            count_inc = r_count;
        end
    end

    always_comb begin
        cmd          = '0;
        n_at_start   = r_at_start;
        n_prev_empty = r_prev_empty;
        if (is_nl) begin
            cmd.num_en   = start_eff && numbering && !i_cfg.number_mode[1];
            n_prev_empty = start_eff;
            n_at_start   = 1'b1;
            if (i_cfg.dollar_eol) begin
                cmd.body_len = 2'd2;
                cmd.body0    = CH_DOLLAR;
                cmd.body1    = CH_NL;
            end else begin
                cmd.body_len = 2'd1;
                cmd.body0    = CH_NL;
            end
        end else begin
            cmd.num_en   = start_eff && numbering;
            n_at_start   = 1'b0;
            n_prev_empty = prev_empty_eff && !start_eff;
            cmd.body_len = 2'd1;
            cmd.body0    = i_data_byte;
            if (i_data_byte >= CH_PRINT_LO && i_data_byte <= CH_PRINT_HI) begin
                cmd.body0 = i_data_byte;
            end else if (i_data_byte == CH_TAB) begin
                if (i_cfg.caret_tab) begin
                    cmd.body_len = 2'd2;
                    cmd.body0    = CH_CARET;
                    cmd.body1    = CH_UPPER_I;
                end
            end else if (!i_cfg.caret_ctrl) begin
                cmd.body0 = i_data_byte;
            end else if (i_data_byte[7]) begin
                cmd.body_len = 2'd3;
                cmd.body0    = CH_UPPER_M;
                cmd.body1    = CH_DASH;
                cmd.body2    = i_data_byte & MASK_LOW7;
            end else if (i_data_byte == CH_DEL) begin
                cmd.body_len = 2'd2;
                cmd.body0    = CH_CARET;
                cmd.body1    = CH_QMARK;
            end else begin
                cmd.body_len = 2'd2;
                cmd.body0    = CH_CARET;
                cmd.body1    = (i_data_byte | MASK_CTRL) & MASK_LOW7;
            end
        end
        n_count = cmd.num_en ? count_inc : r_count;
    end

    assign o_push   = accept && !squeeze;
    assign o_cmd    = cmd;
    assign o_digits = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= CNT_W'(1);
            r_at_start   <= 1'b1;
            r_prev_empty <= 1'b0;
        end else if (accept && !squeeze) begin
            r_count      <= n_count;
            r_at_start   <= n_at_start;
            r_prev_empty <= n_prev_empty;
        end
    end

endmodule

// File: design/tslf_back.sv
// Back section: expand queued commands into output bytes, one per cycle while the receiver is ready.
module tslf_back #(
    parameter int NUMBER_DIGITS = 6
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_empty,
    input  tslf_pkg::t_cmd              i_cmd,
    input  logic [4*NUMBER_DIGITS-1:0]  i_digits,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [7:0]                  o_byte,
    output logic                        o_last
);
    import tslf_pkg::*;

    localparam int NUM_LEN = NUMBER_DIGITS + 2;
    localparam int POS_W   = $clog2(NUM_LEN + 4);
    localparam int DIG_W   = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_valid;
    logic [7:0]       r_byte;
    logic             r_last;

    logic [7:0]       dig_char [NUMBER_DIGITS];
    logic             zero_above;
    logic [3:0]       dig;
    logic [POS_W-1:0] total;
    logic [POS_W-1:0] body_pos;
    logic [DIG_W-1:0] dig_sel;
    logic             load;
    logic             last;
    logic [7:0]       cur_byte;

    // digit characters with leading zeros shown as spaces
    always_comb begin
        zero_above = 1'b1;
        for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
            dig = i_digits[4*i +: 4];
            if (dig > 4'd9) begin
                dig = 4'd9;
            end
            if (zero_above && dig == 4'd0 && i != 0) begin
                dig_char[i] = CH_SPACE;
            end else begin
                dig_char[i] = CH_ZERO + {4'd0, dig};
            end
            zero_above = zero_above && (dig == 4'd0);
        end
    end

    always_comb begin
        total    = i_cmd.num_en ? POS_W'(NUM_LEN) + POS_W'(i_cmd.body_len)
                                : POS_W'(i_cmd.body_len);
        body_pos = i_cmd.num_en ? r_pos - POS_W'(NUM_LEN) : r_pos;
        dig_sel  = DIG_W'(POS_W'(NUMBER_DIGITS - 1) - r_pos);
        last     = (r_pos == total - 1'b1);
        if (i_cmd.num_en && r_pos < POS_W'(NUMBER_DIGITS)) begin
            cur_byte = dig_char[dig_sel];
        end else if (i_cmd.num_en && r_pos < POS_W'(NUM_LEN)) begin
            cur_byte = CH_SPACE;
        end else begin
            case (body_pos[1:0])
                2'd0:    cur_byte = i_cmd.body0;
                2'd1:    cur_byte = i_cmd.body1;
                default: cur_byte = i_cmd.body2;
            endcase
        end
    end

    assign load  = !i_q_empty && (!r_valid || i_ready);
    assign o_pop = load && last;
    assign n_pos = (load && last) ? '0 : (load ? r_pos + 1'b1 : r_pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_pos <= n_pos;
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= cur_byte;
            r_last <= last;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

endmodule

// File: design/text_stream_line_formatter_unit.sv
// Top level of the text stream line formatter: configuration registers and section wiring.
//
//  channel   | dir | handshake           | payload
//  ----------+-----+---------------------+------------------------------------------
//  s stream  | in  | i_s_tvalid/o_s_tready | tdata: data_byte[7:0]; tuser: file_start
//  m stream  | out | o_m_tvalid/i_m_tready | tdata: out_byte[7:0]; tlast: last_of_run
//  cfg write | in  | i_cfg_we            | i_cfg_idx register index, i_cfg_wdata value
//
//  One output byte leaves per cycle while the receiver is ready; an input byte yields
//  1 to NUMBER_DIGITS+5 output bytes, set by the back section's byte sequencer.
//  Input bytes enter at one per cycle while the command queue has room.
//  A squeezed newline is accepted but produces nothing.
//  Reset is synchronous, active low, and clears configuration, line state and queue.
module text_stream_line_formatter_unit #(
    parameter int NUMBER_DIGITS = 6
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [7:0]                         i_s_tdata,   // data_byte[7:0]
    input  logic                               i_s_tuser,   // file_start
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [7:0]                         o_m_tdata,   // out_byte[7:0]
    output logic                               o_m_tlast,
    input  logic                               i_cfg_we,
    input  logic [tslf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tslf_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import tslf_pkg::*;

    localparam int CMD_W = $bits(t_cmd);
    localparam int DIG_BITS = 4 * NUMBER_DIGITS;
    localparam int Q_W = CMD_W + DIG_BITS;

    t_cfg                r_cfg;
    logic                q_full;
    logic                q_empty;
    logic                push;
    logic                pop;
    t_cmd                front_cmd;
    logic [DIG_BITS-1:0] front_digits;
    logic [Q_W-1:0]      q_dout;
    t_cmd                back_cmd;
    logic [DIG_BITS-1:0] back_digits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NUMBER_MODE:   r_cfg.number_mode   <= i_cfg_wdata[1:0];
                CFG_DOLLAR_EOL:    r_cfg.dollar_eol    <= i_cfg_wdata[0];
                CFG_CARET_TAB:     r_cfg.caret_tab     <= i_cfg_wdata[0];
                CFG_CARET_CTRL:    r_cfg.caret_ctrl    <= i_cfg_wdata[0];
                CFG_SQUEEZE_BLANK: r_cfg.squeeze_blank <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    tslf_front #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_data_byte  (i_s_tdata),
        .i_file_start (i_s_tuser),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_cmd        (front_cmd),
        .o_digits     (front_digits)
    );

    tslf_queue #(
        .W     (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_din   ({front_digits, front_cmd}),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_dout  (q_dout),
        .o_empty (q_empty)
    );

    assign back_cmd    = q_dout[CMD_W-1:0];
    assign back_digits = q_dout[Q_W-1:CMD_W];

    tslf_back #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_cmd     (back_cmd),
        .i_digits  (back_digits),
        .o_pop     (pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_byte    (o_m_tdata),
        .o_last    (o_m_tlast)
    );

endmodule
